[src/terminal_line_echo_engine_assert.svh]
`ifndef TERMINAL_LINE_ECHO_ENGINE_ASSERT_SVH
`define TERMINAL_LINE_ECHO_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TLE_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define TLE_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TLE_ASSERT_IMP(label, clk, rstn, a, c)
`define TLE_ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

[src/tle_pkg.sv]
package tle_pkg;
    localparam int TERMINALS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 128;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] LINE_MAX = 8'hFF;

    typedef enum logic [1:0] {OP_RX = 2'd0, OP_TXDONE = 2'd1, OP_WRITE = 2'd2,
                              OP_READ = 2'd3} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_DISABLED = 2'd1, ST_OUT_FULL = 2'd2,
                              ST_IN_EMPTY = 2'd3} status_t;
    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_OUT} state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_t;
endpackage

[src/tle_ctrl.sv]
module tle_ctrl
    import tle_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    output logic   m_valid,
    input  logic   m_ready,
    output ctrl_t  ctrl
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_READ;
            S_READ: state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_OUT);
        ctrl.load = (state_reg == S_IDLE) && s_valid;
        ctrl.exec = (state_reg == S_EXEC);
    end
endmodule

[src/tle_datapath.sv]
module tle_datapath
    import tle_pkg::*;
#(
    parameter int TERMINALS = TERMINALS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_t      ctrl,
    input  logic [3:0] enable,
    input  logic [1:0] s_operation,
    input  logic [1:0] s_terminal,
    input  logic [7:0] s_char_in,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_char,
    output logic       m_read_valid,
    output logic [7:0] m_read_char,
    output logic       m_line_end,
    output logic [1:0] m_status
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int AW = TW + PW;
    localparam logic [FW-1:0] QD = FW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] PMAX = PW'(QUEUE_DEPTH - 1);

    logic [7:0] in_mem  [2**AW];
    logic [7:0] ech_mem [2**AW];
    logic [7:0] out_mem [2**AW];
    logic [PW-1:0] ih_reg [TERMINALS], it_reg [TERMINALS];
    logic [PW-1:0] eh_reg [TERMINALS], et_reg [TERMINALS];
    logic [PW-1:0] oh_reg [TERMINALS], ot_reg [TERMINALS];
    logic [FW-1:0] ifl_reg [TERMINALS], efl_reg [TERMINALS], ofl_reg [TERMINALS];
    logic [7:0] ll_reg [TERMINALS];
    logic [7:0] se_reg [TERMINALS][2];
    logic [7:0] so_reg [TERMINALS][2];
    logic se_h_reg [TERMINALS], se_t_reg [TERMINALS];
    logic so_h_reg [TERMINALS], so_t_reg [TERMINALS];
    logic [1:0] se_f_reg [TERMINALS], so_f_reg [TERMINALS];
    logic busy_reg [TERMINALS];

    logic [1:0] op_reg;
    logic [1:0] t_reg;
    logic [7:0] c_reg;
    logic [7:0] ird_reg, erd_reg, ord_reg;
    logic rd_stage_reg;

    logic [TW-1:0] ti;
    assign ti = TW'(t_reg);

    function automatic logic [PW-1:0] pinc(input logic [PW-1:0] p);
        return (p == PMAX) ? '0 : p + 1'b1;
    endfunction
    function automatic logic [PW-1:0] pdec(input logic [PW-1:0] p);
        return (p == '0) ? PMAX : p - 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            op_reg <= s_operation;
            t_reg <= s_terminal;
            c_reg <= s_char_in;
        end
        rd_stage_reg <= ctrl.load;
    end

    always_ff @(posedge aclk) begin
        if (rd_stage_reg) begin
            ird_reg <= in_mem[{ti, it_reg[ti]}];
            erd_reg <= ech_mem[{ti, et_reg[ti]}];
            ord_reg <= out_mem[{ti, ot_reg[ti]}];
        end
    end

    logic dis;
    logic ok;
    assign dis = (32'(t_reg) >= TERMINALS) || !enable[t_reg];
    assign ok = ctrl.exec && !dis;

    logic in_wr, ech_wr, out_wr;
    logic [7:0] in_wd, ech_wd;
    always_comb begin
        in_wr = 1'b0; in_wd = c_reg; ech_wr = 1'b0; ech_wd = c_reg; out_wr = 1'b0;
        if (ok) begin
            unique case (op_t'(op_reg))
                OP_RX: begin
                    if (c_reg == CH_CR || c_reg == CH_LF) begin
                        in_wr = ifl_reg[ti] < QD; in_wd = CH_LF;
                        ech_wr = busy_reg[ti] && efl_reg[ti] < QD; ech_wd = CH_CR;
                    end else if (c_reg == CH_BS || c_reg == CH_DEL) begin
                        ech_wr = busy_reg[ti] && efl_reg[ti] < QD;
                        ech_wd = (ifl_reg[ti] != '0 && ll_reg[ti] != '0) ? CH_BS : CH_BEL;
                    end else begin
                        in_wr = ifl_reg[ti] < QD;
                        ech_wr = busy_reg[ti] && efl_reg[ti] < QD;
                        ech_wd = (ifl_reg[ti] < QD) ? c_reg : CH_BEL;
                    end
                end
                OP_WRITE: out_wr = ofl_reg[ti] < QD && busy_reg[ti];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_wr) in_mem[{ti, ih_reg[ti]}] <= in_wd;
        if (ech_wr) ech_mem[{ti, eh_reg[ti]}] <= ech_wd;
        if (out_wr) out_mem[{ti, oh_reg[ti]}] <= c_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TERMINALS; i++) begin
                ih_reg[i] <= '0; it_reg[i] <= '0; ifl_reg[i] <= '0;
                eh_reg[i] <= '0; et_reg[i] <= '0; efl_reg[i] <= '0;
                oh_reg[i] <= '0; ot_reg[i] <= '0; ofl_reg[i] <= '0;
                ll_reg[i] <= '0; busy_reg[i] <= 1'b0;
                se_h_reg[i] <= 1'b0; se_t_reg[i] <= 1'b0; se_f_reg[i] <= '0;
                so_h_reg[i] <= 1'b0; so_t_reg[i] <= 1'b0; so_f_reg[i] <= '0;
            end
            m_tx_valid <= 1'b0; m_tx_char <= '0; m_read_valid <= 1'b0;
            m_read_char <= '0; m_line_end <= 1'b0; m_status <= ST_OK;
        end else if (ctrl.exec) begin
            m_tx_valid <= 1'b0; m_tx_char <= '0; m_read_valid <= 1'b0;
            m_read_char <= '0; m_line_end <= 1'b0; m_status <= ST_OK;
            if (dis) begin
                m_status <= ST_DISABLED;
            end else begin
                unique case (op_t'(op_reg))
                    OP_RX: begin
                        if (!busy_reg[ti]) begin
                            busy_reg[ti] <= 1'b1; m_tx_valid <= 1'b1; m_tx_char <= ech_wd;
                        end else if (ech_wr) begin
                            eh_reg[ti] <= pinc(eh_reg[ti]); efl_reg[ti] <= efl_reg[ti] + 1'b1;
                        end
                        if (in_wr) begin
                            ih_reg[ti] <= pinc(ih_reg[ti]); ifl_reg[ti] <= ifl_reg[ti] + 1'b1;
                        end
                        if (c_reg == CH_CR || c_reg == CH_LF) begin
                            ll_reg[ti] <= '0;
                            if (se_f_reg[ti] < 2'd2) begin
                                se_reg[ti][se_h_reg[ti]] <= CH_LF;
                                se_h_reg[ti] <= ~se_h_reg[ti];
                                se_f_reg[ti] <= se_f_reg[ti] + 1'b1;
                            end
                        end else if (c_reg == CH_BS || c_reg == CH_DEL) begin
                            if (ifl_reg[ti] != '0 && ll_reg[ti] != '0) begin
                                ih_reg[ti] <= pdec(ih_reg[ti]);
                                ifl_reg[ti] <= ifl_reg[ti] - 1'b1;
                                ll_reg[ti] <= ll_reg[ti] - 1'b1;
                                if (se_f_reg[ti] == 2'd0) begin
                                    se_reg[ti][se_h_reg[ti]] <= CH_SP;
                                    se_reg[ti][~se_h_reg[ti]] <= CH_BS;
                                    se_f_reg[ti] <= 2'd2;
                                end else if (se_f_reg[ti] == 2'd1) begin
                                    se_reg[ti][se_h_reg[ti]] <= CH_SP;
                                    se_h_reg[ti] <= ~se_h_reg[ti];
                                    se_f_reg[ti] <= 2'd2;
                                end
                            end
                        end else if (in_wr && ll_reg[ti] != LINE_MAX) begin
                            ll_reg[ti] <= ll_reg[ti] + 1'b1;
                        end
                    end
                    OP_TXDONE: begin
                        busy_reg[ti] <= 1'b1; m_tx_valid <= 1'b1;
                        if (se_f_reg[ti] != '0) begin
                            m_tx_char <= se_reg[ti][se_t_reg[ti]];
                            se_t_reg[ti] <= ~se_t_reg[ti];
                            se_f_reg[ti] <= se_f_reg[ti] - 1'b1;
                        end else if (efl_reg[ti] != '0) begin
                            m_tx_char <= erd_reg;
                            et_reg[ti] <= pinc(et_reg[ti]);
                            efl_reg[ti] <= efl_reg[ti] - 1'b1;
                        end else if (so_f_reg[ti] != '0) begin
                            m_tx_char <= so_reg[ti][so_t_reg[ti]];
                            so_t_reg[ti] <= ~so_t_reg[ti];
                            so_f_reg[ti] <= so_f_reg[ti] - 1'b1;
                        end else if (ofl_reg[ti] != '0) begin
                            ot_reg[ti] <= pinc(ot_reg[ti]);
                            ofl_reg[ti] <= ofl_reg[ti] - 1'b1;
                            if (ord_reg == CH_LF) begin
                                m_tx_char <= CH_CR;
                                so_reg[ti][so_h_reg[ti]] <= CH_LF;
                                so_h_reg[ti] <= ~so_h_reg[ti];
                                so_f_reg[ti] <= 2'd1;
                            end else begin
                                m_tx_char <= ord_reg;
                            end
                        end else begin
                            busy_reg[ti] <= 1'b0; m_tx_valid <= 1'b0;
                        end
                    end
                    OP_WRITE: begin
                        if (ofl_reg[ti] >= QD) begin
                            m_status <= ST_OUT_FULL;
                        end else if (!busy_reg[ti]) begin
                            busy_reg[ti] <= 1'b1; m_tx_valid <= 1'b1;
                            if (c_reg == CH_LF) begin
                                m_tx_char <= CH_CR; ll_reg[ti] <= '0;
                                if (so_f_reg[ti] < 2'd2) begin
                                    so_reg[ti][so_h_reg[ti]] <= CH_LF;
                                    so_h_reg[ti] <= ~so_h_reg[ti];
                                    so_f_reg[ti] <= so_f_reg[ti] + 1'b1;
                                end
                            end else begin
                                m_tx_char <= c_reg;
                                if (ll_reg[ti] != LINE_MAX) ll_reg[ti] <= ll_reg[ti] + 1'b1;
                            end
                        end else begin
                            oh_reg[ti] <= pinc(oh_reg[ti]); ofl_reg[ti] <= ofl_reg[ti] + 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (ifl_reg[ti] == '0) begin
                            m_status <= ST_IN_EMPTY;
                        end else begin
                            m_read_valid <= 1'b1; m_read_char <= ird_reg;
                            m_line_end <= (ird_reg == CH_LF);
                            it_reg[ti] <= pinc(it_reg[ti]);
                            ifl_reg[ti] <= ifl_reg[ti] - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

[src/terminal_line_echo_engine.sv]
// line discipline for up to TERMINALS serial terminals with per-terminal input, echo
// and output rings: a result is offered after its input transfer passes the S_READ
// (ring memory read) and S_EXEC (update) states, and the next input is taken in the
// cycle after the result transfer; a result that waits holds off the input
`include "terminal_line_echo_engine_assert.svh"
module terminal_line_echo_engine
    import tle_pkg::*;
#(
    parameter int TERMINALS = TERMINALS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [1:0] s_terminal,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_char,
    output logic       m_read_valid,
    output logic [7:0] m_read_char,
    output logic       m_line_end,
    output logic [1:0] m_status
);
    logic [3:0] enable_reg;
    ctrl_t ctrl;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) enable_reg <= '0;
        else if (cfg_valid) enable_reg <= cfg_data;
    end

    tle_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .ctrl(ctrl)
    );

    tle_datapath #(.TERMINALS(TERMINALS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .enable(enable_reg),
        .s_operation(s_operation), .s_terminal(s_terminal), .s_char_in(s_char_in),
        .m_tx_valid(m_tx_valid), .m_tx_char(m_tx_char), .m_read_valid(m_read_valid),
        .m_read_char(m_read_char), .m_line_end(m_line_end), .m_status(m_status)
    );

    `TLE_ASSERT_IMP(a_no_both, aclk, aresetn, m_valid, !(s_ready && m_valid))
    `TLE_ASSERT_IMP(a_read_ok, aclk, aresetn, m_valid && m_read_valid, m_status == ST_OK)
    `TLE_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_tx_char))
endmodule
